// ===== src/fcfs_schedule_timing_macros.svh =====
// assertion macros for the fcfs scheduler
`ifndef FCFS_SCHEDULE_TIMING_MACROS_SVH
`define FCFS_SCHEDULE_TIMING_MACROS_SVH

`ifndef SYNTHESIS

`define FCFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcfs assertion failed");

`define FCFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcfs assertion failed");

`else

`define FCFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define FCFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/fcfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fcfs_pkg;

  localparam int unsigned ARR_W        = 16;
  localparam int unsigned BUR_W        = 16;
  localparam int unsigned NUM_W        = 7;
  localparam int unsigned TIME_W       = 23;
  localparam int unsigned SUM_W        = 29;
  localparam int unsigned MAX_JOBS_DEF = 64;

  typedef struct packed {
    logic [ARR_W-1:0] arrival;
    logic [BUR_W-1:0] burst;
  } entry_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_PREP,
    ST_EMIT
  } state_e;

  // sequencer to timeline strobes
  typedef struct packed {
    logic prep;
    logic emit;
    logic first;
    logic last;
  } tl_ctrl_t;

endpackage

`default_nettype wire

// ===== src/fcfs_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fcfs_store
  import fcfs_pkg::*;
#(
  parameter int unsigned MAX_JOBS = MAX_JOBS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        wr_en_i,
  input  wire logic [$clog2(MAX_JOBS)-1:0] wr_addr_i,
  input  wire entry_t                      wr_data_i,
  input  wire logic                        rd_en_i,
  input  wire logic [$clog2(MAX_JOBS)-1:0] rd_addr_i,
  output entry_t                           rd_data_o
);

  entry_t mem_q [MAX_JOBS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/fcfs_timeline.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fcfs_timeline
  import fcfs_pkg::*;
#(
  parameter int unsigned MAX_JOBS = MAX_JOBS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire tl_ctrl_t                    ctrl_i,
  input  wire logic [ARR_W-1:0]            arrival_i,
  input  wire logic [BUR_W-1:0]            burst_i,
  input  wire logic [$clog2(MAX_JOBS)-1:0] idx_i,
  output logic                             slot_free_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [NUM_W-1:0]                 job_number_o,
  output logic [ARR_W-1:0]                 arrival_out_o,
  output logic [BUR_W-1:0]                 burst_out_o,
  output logic [TIME_W-1:0]                completion_time_o,
  output logic [TIME_W-1:0]                turnaround_time_o,
  output logic [TIME_W-1:0]                waiting_time_o,
  output logic [SUM_W-1:0]                 turnaround_sum_o,
  output logic [SUM_W-1:0]                 waiting_sum_o,
  output logic                             final_result_o
);

  localparam int unsigned IW  = $clog2(MAX_JOBS);
  localparam int unsigned CNW = $clog2(MAX_JOBS + 1);
  // clock never exceeds the latest arrival plus every burst
  localparam int unsigned CW  = ARR_W + CNW;

  logic [CW-1:0]    clock_q, clock_d;
  logic [CW-1:0]    start_q, start_d;
  logic [CW-1:0]    wait_q, wait_d;
  logic [ARR_W-1:0] arr_q;
  logic [BUR_W-1:0] bur_q;
  logic [IW-1:0]    idx_q;
  logic [SUM_W-1:0] tacc_q, tacc_d;
  logic [SUM_W-1:0] wacc_q, wacc_d;
  logic             valid_q, valid_d;
  logic [CW-1:0]    base;
  logic [CW-1:0]    done;
  logic [CW-1:0]    turn;

  assign slot_free_o = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;

  always_comb begin
    base    = ctrl_i.first ? '0 : clock_q;
    start_d = (base < CW'(arrival_i)) ? CW'(arrival_i) : base;
    wait_d  = start_d - CW'(arrival_i);
    done    = start_q + CW'(bur_q);
    turn    = wait_q + CW'(bur_q);
    clock_d = clock_q;
    tacc_d  = tacc_q;
    wacc_d  = wacc_q;
    valid_d = valid_q && out_stall_i;
    if (ctrl_i.prep && ctrl_i.first) begin
      tacc_d = '0;
      wacc_d = '0;
    end
    if (ctrl_i.emit) begin
      clock_d = done;
      tacc_d  = tacc_q + SUM_W'(turn);
      wacc_d  = wacc_q + SUM_W'(wait_q);
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= '0;
      tacc_q  <= '0;
      wacc_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      clock_q <= clock_d;
      tacc_q  <= tacc_d;
      wacc_q  <= wacc_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.prep) begin
      start_q <= start_d;
      wait_q  <= wait_d;
      arr_q   <= arrival_i;
      bur_q   <= burst_i;
      idx_q   <= idx_i;
    end
    if (ctrl_i.emit) begin
      job_number_o      <= NUM_W'(CNW'(idx_q) + CNW'(1));
      arrival_out_o     <= arr_q;
      burst_out_o       <= bur_q;
      completion_time_o <= TIME_W'(done);
      turnaround_time_o <= TIME_W'(turn);
      waiting_time_o    <= TIME_W'(wait_q);
      turnaround_sum_o  <= tacc_d;
      waiting_sum_o     <= wacc_d;
      final_result_o    <= ctrl_i.last;
    end
  end

endmodule

`default_nettype wire

// ===== src/fcfs_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "fcfs_schedule_timing_macros.svh"

module fcfs_seq
  import fcfs_pkg::*;
#(
  parameter int unsigned MAX_JOBS = MAX_JOBS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        last_job_i,
  output logic                             wr_en_o,
  output logic [$clog2(MAX_JOBS)-1:0]      wr_addr_o,
  output logic                             rd_en_o,
  output logic [$clog2(MAX_JOBS)-1:0]      rd_addr_o,
  input  wire entry_t                      rd_data_i,
  input  wire logic                        slot_free_i,
  output tl_ctrl_t                         ctrl_o,
  output logic [ARR_W-1:0]                 arrival_o,
  output logic [BUR_W-1:0]                 burst_o,
  output logic [$clog2(MAX_JOBS)-1:0]      idx_o
);

  localparam int unsigned IW  = $clog2(MAX_JOBS);
  localparam int unsigned CNW = $clog2(MAX_JOBS + 1);
  localparam int unsigned KW  = ARR_W + IW;

  state_e         state_q, state_d;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic [CNW-1:0] iss_q, iss_d;
  logic [CNW-1:0] pos_q, pos_d;
  logic           pend_q, pend_d;
  logic [IW-1:0]  pidx_q, pidx_d;
  logic [KW-1:0]  last_key_q, last_key_d;
  logic           have_last_q, have_last_d;
  logic [KW-1:0]  best_key_q, best_key_d;
  logic [BUR_W-1:0] best_bur_q, best_bur_d;
  logic           have_best_q, have_best_d;
  logic [KW-1:0]  key;
  logic           cand;
  logic           accept;
  logic           final_job;

  // key ties on arrival resolve by load position, giving a stable order
  assign key       = {rd_data_i.arrival, pidx_q};
  assign cand      = (!have_last_q || key > last_key_q) && (!have_best_q || key < best_key_q);
  assign accept    = in_valid_i && !in_stall_o;
  assign final_job = (pos_q + CNW'(1)) == cnt_q;

  assign arrival_o = best_key_q[KW-1 -: ARR_W];
  assign idx_o     = best_key_q[IW-1:0];
  assign burst_o   = best_bur_q;
  assign wr_addr_o = cnt_q[IW-1:0];
  assign rd_addr_o = iss_q[IW-1:0];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    iss_d       = iss_q;
    pos_d       = pos_q;
    pend_d      = 1'b0;
    pidx_d      = pidx_q;
    last_key_d  = last_key_q;
    have_last_d = have_last_q;
    best_key_d  = best_key_q;
    best_bur_d  = best_bur_q;
    have_best_d = have_best_q;
    in_stall_o  = 1'b1;
    wr_en_o     = 1'b0;
    rd_en_o     = 1'b0;
    ctrl_o      = '0;
    ctrl_o.first = (pos_q == '0);
    ctrl_o.last  = final_job;
    case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (accept) begin
          wr_en_o = 1'b1;
          cnt_d   = cnt_q + CNW'(1);
          if (last_job_i || (cnt_q + CNW'(1)) == CNW'(MAX_JOBS)) begin
            state_d     = ST_SCAN;
            iss_d       = '0;
            pos_d       = '0;
            have_last_d = 1'b0;
            have_best_d = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (iss_q != cnt_q) begin
          rd_en_o = 1'b1;
          iss_d   = iss_q + CNW'(1);
          pend_d  = 1'b1;
          pidx_d  = iss_q[IW-1:0];
        end else if (!pend_q) begin
          state_d = ST_PREP;
        end
        if (pend_q && cand) begin
          best_key_d  = key;
          best_bur_d  = rd_data_i.burst;
          have_best_d = 1'b1;
        end
      end
      ST_PREP: begin
        ctrl_o.prep = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free_i) begin
          ctrl_o.emit = 1'b1;
          last_key_d  = best_key_q;
          have_last_d = 1'b1;
          have_best_d = 1'b0;
          iss_d       = '0;
          pos_d       = pos_q + CNW'(1);
          if (final_job) begin
            state_d = ST_LOAD;
            cnt_d   = '0;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      iss_q       <= '0;
      pos_q       <= '0;
      pend_q      <= 1'b0;
      have_last_q <= 1'b0;
      have_best_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      iss_q       <= iss_d;
      pos_q       <= pos_d;
      pend_q      <= pend_d;
      have_last_q <= have_last_d;
      have_best_q <= have_best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q     <= pidx_d;
    last_key_q <= last_key_d;
    best_key_q <= best_key_d;
    best_bur_q <= best_bur_d;
  end

  `FCFS_ASSERT_IMP(a_emit_slot, clk_i, rst_ni, ctrl_o.emit, slot_free_i)
  `FCFS_ASSERT_IMP(a_scan_bound, clk_i, rst_ni, state_q == ST_SCAN, iss_q <= cnt_q)
  `FCFS_ASSERT_NXT(a_prep_emit, clk_i, rst_ni, state_q == ST_PREP, state_q == ST_EMIT)
  `FCFS_ASSERT_IMP(a_pick_found, clk_i, rst_ni, state_q == ST_SCAN && state_d == ST_PREP,
                   have_best_q)
  `FCFS_ASSERT_IMP(a_pos_bound, clk_i, rst_ni, state_q != ST_LOAD, pos_q < cnt_q)

endmodule

`default_nettype wire

// ===== src/fcfs_schedule_timing.sv =====
`timescale 1ns / 1ps
`default_nettype none

// first-come-first-served scheduler: jobs are loaded one per input transfer
// until last_job_i or until MAX_JOBS are held, then the set is ordered by
// arrival (ties keep load order) and one result per job is sent in schedule
// order. the selection of each job is a scan of the whole job memory
// through its single read port and one key comparator, so every result
// waits for a full scan plus any output stall; no input is taken while a
// set is being scheduled. the output register lets a new load start while
// the final result of the previous set is still waiting.
module fcfs_schedule_timing
  import fcfs_pkg::*;
#(
  parameter int unsigned MAX_JOBS = MAX_JOBS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [ARR_W-1:0]  arrival_time_i,
  input  wire logic [BUR_W-1:0]  burst_length_i,
  input  wire logic              last_job_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [NUM_W-1:0]       job_number_o,
  output logic [ARR_W-1:0]       arrival_out_o,
  output logic [BUR_W-1:0]       burst_out_o,
  output logic [TIME_W-1:0]      completion_time_o,
  output logic [TIME_W-1:0]      turnaround_time_o,
  output logic [TIME_W-1:0]      waiting_time_o,
  output logic [SUM_W-1:0]       turnaround_sum_o,
  output logic [SUM_W-1:0]       waiting_sum_o,
  output logic                   final_result_o
);

  localparam int unsigned IW = $clog2(MAX_JOBS);

  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  entry_t           wr_data;
  entry_t           rd_data;
  logic             slot_free;
  tl_ctrl_t         ctrl;
  logic [ARR_W-1:0] sel_arrival;
  logic [BUR_W-1:0] sel_burst;
  logic [IW-1:0]    sel_idx;

  assign wr_data.arrival = arrival_time_i;
  assign wr_data.burst   = burst_length_i;

  fcfs_store #(
    .MAX_JOBS (MAX_JOBS)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  fcfs_timeline #(
    .MAX_JOBS (MAX_JOBS)
  ) u_timeline (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .arrival_i         (sel_arrival),
    .burst_i           (sel_burst),
    .idx_i             (sel_idx),
    .slot_free_o       (slot_free),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .job_number_o      (job_number_o),
    .arrival_out_o     (arrival_out_o),
    .burst_out_o       (burst_out_o),
    .completion_time_o (completion_time_o),
    .turnaround_time_o (turnaround_time_o),
    .waiting_time_o    (waiting_time_o),
    .turnaround_sum_o  (turnaround_sum_o),
    .waiting_sum_o     (waiting_sum_o),
    .final_result_o    (final_result_o)
  );

  fcfs_seq #(
    .MAX_JOBS (MAX_JOBS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .last_job_i  (last_job_i),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .slot_free_i (slot_free),
    .ctrl_o      (ctrl),
    .arrival_o   (sel_arrival),
    .burst_o     (sel_burst),
    .idx_o       (sel_idx)
  );

endmodule

`default_nettype wire
